// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the phase-shift PWM block.
// No dependencies; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an implication on every rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds at a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/dbps_pkg.sv -----
// Shared constants, register codes and payload types of the dual-bridge
// phase-shift PWM block. No dependencies.
package dbps_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int RATIO_FRAC_BITS = 15;
  localparam int FRAC_WIDTH      = RATIO_FRAC_BITS + 1;
  localparam int PHASE_WIDTH     = COUNT_WIDTH + 1;
  localparam int X_WIDTH         = RATIO_FRAC_BITS + 2;
  localparam int PROD_WIDTH      = X_WIDTH + COUNT_WIDTH;
  localparam int DEAD_WIDTH      = 10;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int NUM_LEGS        = 4;

  localparam logic [FRAC_WIDTH-1:0]  RATIO_ONE         = FRAC_WIDTH'(1) << RATIO_FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] HALF_PERIOD_RESET = COUNT_WIDTH'(5000);

  // Leg order inside the raw and gate vectors.
  localparam int LEG_PRI_A = 0;
  localparam int LEG_PRI_B = 1;
  localparam int LEG_SEC_A = 2;
  localparam int LEG_SEC_B = 3;

  typedef enum logic [0:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_DEAD_TICKS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FRAC_WIDTH-1:0] d1_frac;
    logic [FRAC_WIDTH-1:0] d2_frac;
  } pwm_req_t;

  typedef struct packed {
    logic                   pri_a_hi;
    logic                   pri_a_lo;
    logic                   pri_b_hi;
    logic                   pri_b_lo;
    logic                   sec_a_hi;
    logic                   sec_a_lo;
    logic                   sec_b_hi;
    logic                   sec_b_lo;
    logic [COUNT_WIDTH-1:0] carrier_level;
  } pwm_res_t;

  // Contents of the input register: one tick with its carrier value.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] carrier;
    logic [FRAC_WIDTH-1:0]  d1_frac;
    logic [FRAC_WIDTH-1:0]  d2_frac;
  } tick_t;

endpackage

// ----- rtl/dbps_carrier.sv -----
// Phase counter and triangle carrier of the phase-shift PWM block.
// Depends on dbps_pkg.
module dbps_carrier
  import dbps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic [COUNT_WIDTH-1:0] half_period_i,
  output logic [COUNT_WIDTH-1:0] carrier_o,
  output logic [PHASE_WIDTH-1:0] phase_o
);

  logic [PHASE_WIDTH-1:0] phase_q, phase_d;
  logic [PHASE_WIDTH-1:0] period;
  logic [PHASE_WIDTH:0]   phase_inc;

  assign period    = {half_period_i, 1'b0};
  assign phase_inc = {1'b0, phase_q} + (PHASE_WIDTH+1)'(1);

  always_comb begin
    if (phase_q < {1'b0, half_period_i}) begin
      carrier_o = phase_q[COUNT_WIDTH-1:0];
    end else if (phase_q < period) begin
      carrier_o = COUNT_WIDTH'(period - phase_q);
    end else begin
      // counter left beyond a shortened period: read zero, wrap next
      carrier_o = '0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (advance_i) begin
      if (phase_inc >= {1'b0, period}) begin
        phase_d = '0;
      end else begin
        phase_d = phase_inc[PHASE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

// ----- rtl/dbps_modulator.sv -----
// Modulation levels and carrier compare: four raw legs from one tick.
// Depends on dbps_pkg.
module dbps_modulator
  import dbps_pkg::*;
(
  input  tick_t                  tick_i,
  input  logic [COUNT_WIDTH-1:0] half_period_i,
  output logic [NUM_LEGS-1:0]    raw_o
);

  logic [FRAC_WIDTH-1:0] d1_sat, d2_sat;
  logic [X_WIDTH-1:0]    x_lvl [3];
  logic [PROD_WIDTH-1:0] lhs, half, prod, diff;

  // Clamp ratios to 1.0.
  assign d1_sat = (tick_i.d1_frac > RATIO_ONE) ? RATIO_ONE : tick_i.d1_frac;
  assign d2_sat = (tick_i.d2_frac > RATIO_ONE) ? RATIO_ONE : tick_i.d2_frac;

  assign x_lvl[0] = X_WIDTH'(RATIO_ONE) + X_WIDTH'(d1_sat);
  assign x_lvl[1] = X_WIDTH'(d2_sat);
  assign x_lvl[2] = X_WIDTH'(RATIO_ONE) + X_WIDTH'(d1_sat) + X_WIDTH'(d2_sat);

  // Both sides scaled by 2*F*H, so the compare is exact.
  assign lhs  = PROD_WIDTH'(tick_i.carrier) << (RATIO_FRAC_BITS + 1);
  assign half = PROD_WIDTH'(half_period_i) << RATIO_FRAC_BITS;

  always_comb begin
    raw_o            = '0;
    raw_o[LEG_PRI_A] = (lhs >= half);
    prod = '0;
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      prod = PROD_WIDTH'(x_lvl[i]) * PROD_WIDTH'(half_period_i);
      diff = (prod >= lhs) ? (prod - lhs) : (lhs - prod);
      raw_o[i+1] = (diff >= half);
    end
  end

endmodule

// ----- rtl/dbps_deadtime.sv -----
// Rising-edge dead time for the four legs: delay turn-on, drop at once.
// Depends on dbps_pkg.
module dbps_deadtime
  import dbps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [NUM_LEGS-1:0]   raw_i,
  input  logic [DEAD_WIDTH-1:0] dead_ticks_i,
  output logic [NUM_LEGS-1:0]   gate_o
);

  logic [DEAD_WIDTH-1:0] delay_q [NUM_LEGS];
  logic [DEAD_WIDTH-1:0] delay_d [NUM_LEGS];

  always_comb begin
    for (int i = 0; i < NUM_LEGS; i++) begin
      gate_o[i]  = 1'b0;
      delay_d[i] = '0;
      if (raw_i[i]) begin
        if (delay_q[i] >= dead_ticks_i) begin
          gate_o[i]  = 1'b1;
          delay_d[i] = delay_q[i];
        end else begin
          delay_d[i] = delay_q[i] + DEAD_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        delay_q[i] <= '0;
      end
    end else if (advance_i) begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        delay_q[i] <= delay_d[i];
      end
    end
  end

endmodule

// ----- rtl/dual_bridge_phase_shift_pwm.sv -----
// Phase-shift PWM generator for a dual active bridge. Every request is one
// tick of the PWM time base and carries the two phase-shift ratios D1 and D2
// (unsigned Q1.15, values above 1.0 clamp to 1.0). Each tick gives one result:
// the eight gate drives of both bridges and the triangle carrier value used.
// The block takes one request per clock unless both registers hold work
// and the result is not taken. A tick's result is loaded into the result
// register as the tick leaves the input register. The rate is set by the
// single compute pass between the two, where three 17x16 multiplies and
// their compares work in parallel. While the input register is empty, a
// stalled result does not stop the next request from entering it. half_period
// (register 0, reset 5000) sets the rising half of the carrier; dead_ticks
// (register 1, reset 0) delays every rising upper-gate edge by that many ticks.
// Write the registers only while no request is in flight. Lower gates are
// always the inverse of their upper gates.
// Depends on dbps_pkg, dbps_carrier, dbps_modulator, dbps_deadtime and
// assert_macros.svh.
`include "assert_macros.svh"

module dual_bridge_phase_shift_pwm
  import dbps_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pwm_req_t                  in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pwm_res_t                  out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  cfg_idx_e                  cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i
);

  // Configuration registers.
  logic [COUNT_WIDTH-1:0] half_period_q;
  logic [DEAD_WIDTH-1:0]  dead_ticks_q;

  // Pipeline control.
  logic                   in_fire;
  logic                   s1_valid_q;
  logic                   s1_adv;
  logic                   s1_move;
  logic                   out_valid_q;
  tick_t                  s1_q;
  pwm_res_t               out_q, out_d;

  logic [COUNT_WIDTH-1:0] carrier;
  logic [PHASE_WIDTH-1:0] phase;
  logic [NUM_LEGS-1:0]    raw;
  logic [NUM_LEGS-1:0]    gate;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
      dead_ticks_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i[COUNT_WIDTH-1:0];
        CFG_DEAD_TICKS:  dead_ticks_q  <= cfg_data_i[DEAD_WIDTH-1:0];
      endcase
    end
  end

  // Advance the input register whenever the result register is free or
  // being drained; accept a request whenever the input register can move.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Carrier value belongs to the tick of the accepted request.
  dbps_carrier u_carrier (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (in_fire),
    .half_period_i (half_period_q),
    .carrier_o     (carrier),
    .phase_o       (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.carrier <= carrier;
      s1_q.d1_frac <= in_data_i.d1_frac;
      s1_q.d2_frac <= in_data_i.d2_frac;
    end
  end

  // Single compute pass: compare levels against the carrier, then dead time.
  dbps_modulator u_modulator (
    .tick_i        (s1_q),
    .half_period_i (half_period_q),
    .raw_o         (raw)
  );

  dbps_deadtime u_deadtime (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (s1_move),
    .raw_i        (raw),
    .dead_ticks_i (dead_ticks_q),
    .gate_o       (gate)
  );

  always_comb begin
    out_d.pri_a_hi      = gate[LEG_PRI_A];
    out_d.pri_a_lo      = !gate[LEG_PRI_A];
    out_d.pri_b_hi      = gate[LEG_PRI_B];
    out_d.pri_b_lo      = !gate[LEG_PRI_B];
    out_d.sec_a_hi      = gate[LEG_SEC_A];
    out_d.sec_a_lo      = !gate[LEG_SEC_A];
    out_d.sec_b_hi      = gate[LEG_SEC_B];
    out_d.sec_b_lo      = !gate[LEG_SEC_B];
    out_d.carrier_level = s1_q.carrier;
  end

  // Result register: load on a move, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Back-pressure only when both registers hold work.
  `ASSERT_CLK(a_ready_only_when_full, clk_i, rst_ni,
              !in_ready_o |-> (s1_valid_q && out_valid_q), "ready low with room")
  // A tick leaving the input register always lands in the result register.
  `ASSERT_CLK(a_move_lands, clk_i, rst_ni,
              s1_move |=> out_valid_q, "tick lost between stages")
  // The phase counter steps once per accepted request, else holds.
  `ASSERT_CLK(a_phase_step, clk_i, rst_ni,
              in_fire |=> (phase == $past(phase) + PHASE_WIDTH'(1)) || (phase == '0),
              "phase counter did not step")
  `ASSERT_CLK(a_phase_hold, clk_i, rst_ni,
              !in_fire |=> $stable(phase), "phase counter moved without request")

endmodule
